FILE: src/ajr_pkg.sv
// shared constants and types for the audio jitter ring
package ajr_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int DEPTH_W  = 13;

  // default ring capacity in samples, must be a power of two
  localparam int CAPACITY_DEF = 4096;

  // item command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

endpackage

FILE: src/ajr_ram.sv
// generic single-clock ram with one write port and one registered read port
module ajr_ram #(
  parameter int WIDTH = ajr_pkg::SAMPLE_W,
  parameter int DEPTH = ajr_pkg::CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/audio_jitter_ring_drop_oldest_core.sv
// audio jitter ring that drops the oldest sample when the depth target is exceeded
// every transfer gives its result from registers in the cycle after acceptance
// throughput: one item per cycle, set by the single write and single read port of the ram
// busy is never raised, the result strobe done_o cannot be held off by the receiver
// reset: asynchronous active-low, clears both pointers and the result strobe,
// the sample store is not cleared (only written entries are ever read)
module audio_jitter_ring_drop_oldest_core #(
  parameter int CAPACITY = ajr_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd_i,
  input  logic signed [ajr_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [ajr_pkg::DEPTH_W-1:0]        max_depth_i,
  output logic                               done_o,
  output logic signed [ajr_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                               got_sample_o,
  output logic                               dropped_oldest_o,
  output logic [ajr_pkg::DEPTH_W-1:0]        fill_level_o
);

  // index into the store, pointers carry one extra wrap bit so full and empty differ
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PTR_W = IDX_W + 1;
  // working width for fill and target arithmetic, one bit of headroom for fill + 1
  localparam int EXT_W = ((PTR_W > ajr_pkg::DEPTH_W) ? PTR_W : ajr_pkg::DEPTH_W) + 1;

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] used;

  logic [EXT_W-1:0] used_x, depth_x, cap_x, target_x, used_inc_x, fill_x;

  logic accept, is_read, is_write, has_data, over;

  logic done_q, got_q, dropped_q;
  logic [ajr_pkg::DEPTH_W-1:0] fill_q, fill_d;

  logic [ajr_pkg::SAMPLE_W-1:0] rdata;

  // the ring takes a transfer on every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_read  = accept && (cmd_i == ajr_pkg::CMD_READ);
  assign is_write = accept && (cmd_i == ajr_pkg::CMD_WRITE);

  // current fill, modulo twice the capacity
  assign used       = wr_ptr_q - rd_ptr_q;
  assign used_x     = EXT_W'(used);
  assign used_inc_x = used_x + EXT_W'(1);
  assign has_data   = (used != '0);

  // clamp the depth target to the capacity
  assign depth_x  = EXT_W'(max_depth_i);
  assign cap_x    = EXT_W'(CAPACITY);
  assign target_x = (depth_x > cap_x) ? cap_x : depth_x;

  // write would leave more than the target held
  assign over = used_inc_x > target_x;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_x   = used_x;
    if (is_write) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
      if (over) begin
        // jump the read pointer so exactly the target remains
        rd_ptr_d = wr_ptr_q + PTR_W'(1) - target_x[PTR_W-1:0];
        fill_x   = target_x;
      end else begin
        fill_x = used_inc_x;
      end
    end else if (is_read && has_data) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
      fill_x   = used_x - EXT_W'(1);
    end
  end

  assign fill_d = fill_x[ajr_pkg::DEPTH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      done_q    <= 1'b0;
      got_q     <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      done_q    <= accept;
      got_q     <= is_read && has_data;
      dropped_q <= is_write && over;
    end
  end

  // fill is payload, only meaningful alongside done_q
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fill_q <= fill_d;
    end
  end

  // sample store: a write lands at its accept edge, a read is issued at its
  // accept edge, so two items never touch the ram at the same edge
  ajr_ram #(
    .WIDTH(ajr_pkg::SAMPLE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (is_write),
    .waddr_i(wr_ptr_q[IDX_W-1:0]),
    .wdata_i(sample_in_i),
    .re_i   (is_read && has_data),
    .raddr_i(rd_ptr_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  assign done_o           = done_q;
  assign got_sample_o     = got_q;
  assign dropped_oldest_o = dropped_q;
  assign fill_level_o     = fill_q;
  // zero on underrun and on write
  assign sample_out_o     = got_q ? rdata : '0;

  // fill never exceeds the capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_x <= cap_x)
    else $error("ring fill beyond capacity");

  // a result follows every transfer in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result after transfer");

  // a read of a non-empty ring returns a sample and drops nothing
  a_read_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_read && has_data) |=> (got_sample_o && !dropped_oldest_o))
    else $error("read of held sample not reported");

  // a write advances the write pointer by one
  a_wr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_write |=> (wr_ptr_q == $past(wr_ptr_q) + PTR_W'(1)))
    else $error("write pointer did not advance");

endmodule
